>>> sv/sew_pkg.sv
// shared widths, register codes, payload types and helpers for the shadow edge extrusion block
package sew_pkg;

	localparam int FRAC_BITS  = 4;
	localparam int COORD_BITS = 20;

	localparam int CW   = COORD_BITS;
	localparam int WW   = CW + 1;
	localparam int DXW  = CW + 2;
	localparam int RED  = (CW > 20) ? CW - 20 : 0;
	localparam int MRW  = DXW - RED;
	localparam int SCW  = 14;
	localparam int CHW  = 7;
	localparam int NRMW = 16;
	localparam int OPW  = 10;
	localparam int SQW  = 2 * MRW;
	localparam int L2W  = SQW + 1;
	localparam int NW   = L2W + 16;
	localparam int SQ_STEPS = (NW + 1) / 2;
	localparam int RW   = SQ_STEPS;
	localparam int PRW  = MRW + SCW;
	localparam int NUMW = PRW + FRAC_BITS + 8;
	localparam int QW   = SCW + FRAC_BITS;
	localparam int FW   = ((WW > QW + 1) ? WW : QW + 1) + 1;
	localparam int RXW  = CW + 3;
	localparam int PW   = NRMW + RXW;
	localparam int DW   = PW + 1;
	localparam int IDXW = 3;
	localparam int DLY  = SQ_STEPS + QW;
	localparam int LATENCY = SQ_STEPS + QW + 5;

	typedef enum logic [IDXW-1:0] {
		REG_LIGHT_X, REG_LIGHT_Y, REG_WINDOW_W, REG_WINDOW_H,
		REG_LIGHT_RED, REG_LIGHT_GREEN, REG_LIGHT_BLUE
	} reg_idx_t;

	typedef struct packed {
		logic                 facing;
		logic [CHW-1:0]       red;
		logic [CHW-1:0]       green;
		logic [CHW-1:0]       blue;
		logic signed [WW-1:0] wax;
		logic signed [WW-1:0] way;
		logic signed [WW-1:0] wbx;
		logic signed [WW-1:0] wby;
		logic                 sax;
		logic                 say;
		logic                 sbx;
		logic                 sby;
		logic                 za;
		logic                 zb;
	} side_t;

	typedef struct packed {
		logic [NUMW-1:0] nx;
		logic [NUMW-1:0] ny;
	} num_pair_t;

	typedef struct packed {
		side_t          side;
		logic [L2W-1:0] l2a;
		logic [L2W-1:0] l2b;
		num_pair_t      na;
		num_pair_t      nb;
	} front_t;

	localparam logic signed [FW-1:0] SAT_HI = {{(FW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [FW-1:0] SAT_LO = {{(FW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	function automatic logic [CW-1:0] sat_coord(input logic signed [FW-1:0] v);
		logic [CW-1:0] r;
		if (v > SAT_HI) r = SAT_HI[CW-1:0];
		else if (v < SAT_LO) r = SAT_LO[CW-1:0];
		else r = v[CW-1:0];
		return r;
	endfunction

	function automatic logic [CHW-1:0] shade_ch(input logic [CHW-1:0] lc,
		input logic [CHW-1:0] ec, input logic signed [OPW-1:0] op);
		logic signed [CHW+OPW:0] q;
		logic [OPW-1:0] h;
		logic [CHW-1:0] r;
		q = $signed({1'b0, lc & ec}) * op;
		h = q[CHW+OPW:8];
		if (q <= 0) r = '0;
		else if (h > OPW'(127)) r = CHW'(127);
		else r = h[CHW-1:0];
		return r;
	endfunction

endpackage

>>> sv/sew_front.sv
// front stages: world coordinates, facing test, light directions, squares and numerators
module sew_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_vld,
	input  logic signed [sew_pkg::CW-1:0]  obstacle_x,
	input  logic signed [sew_pkg::CW-1:0]  obstacle_y,
	input  logic signed [sew_pkg::CW-1:0]  vertex_a_x,
	input  logic signed [sew_pkg::CW-1:0]  vertex_a_y,
	input  logic signed [sew_pkg::CW-1:0]  vertex_b_x,
	input  logic signed [sew_pkg::CW-1:0]  vertex_b_y,
	input  logic signed [sew_pkg::NRMW-1:0] normal_x,
	input  logic signed [sew_pkg::NRMW-1:0] normal_y,
	input  logic [sew_pkg::CHW-1:0]        edge_red,
	input  logic [sew_pkg::CHW-1:0]        edge_green,
	input  logic [sew_pkg::CHW-1:0]        edge_blue,
	input  logic signed [sew_pkg::OPW-1:0] opacity,
	input  logic signed [sew_pkg::CW-1:0]  light_x,
	input  logic signed [sew_pkg::CW-1:0]  light_y,
	input  logic [sew_pkg::SCW-1:0]        window_width,
	input  logic [sew_pkg::SCW-1:0]        window_height,
	input  logic [sew_pkg::CHW-1:0]        light_red,
	input  logic [sew_pkg::CHW-1:0]        light_green,
	input  logic [sew_pkg::CHW-1:0]        light_blue,
	output logic                           out_vld,
	output sew_pkg::front_t                fo
);
	import sew_pkg::*;

	function automatic logic [MRW-1:0] red_mag(input logic signed [DXW-1:0] d);
		logic [DXW-1:0] m;
		m = d[DXW-1] ? DXW'(-d) : DXW'(d);
		return MRW'(m >> RED);
	endfunction

	// stage 1
	logic                   vld_s1;
	logic signed [WW-1:0]   wax_s1, way_s1, wbx_s1, wby_s1;
	logic signed [RXW-1:0]  rx_s1, ry_s1;
	logic signed [NRMW-1:0] nx_s1, ny_s1;
	logic [CHW-1:0]         r_s1, g_s1, b_s1;
	// stage 2
	logic                   vld_s2;
	logic signed [PW-1:0]   px_s2, py_s2;
	logic signed [DXW-1:0]  dax_s2, day_s2, dbx_s2, dby_s2;
	logic signed [WW-1:0]   wax_s2, way_s2, wbx_s2, wby_s2;
	logic [CHW-1:0]         r_s2, g_s2, b_s2;
	// stage 3
	logic                   vld_s3;
	logic                   facing_s3;
	logic [SQW-1:0]         sqax_s3, sqay_s3, sqbx_s3, sqby_s3;
	logic [PRW-1:0]         prax_s3, pray_s3, prbx_s3, prby_s3;
	logic                   sax_s3, say_s3, sbx_s3, sby_s3;
	logic signed [WW-1:0]   wax_s3, way_s3, wbx_s3, wby_s3;
	logic [CHW-1:0]         r_s3, g_s3, b_s3;
	// stage 4
	logic                   vld_s4;
	front_t                 fo_s4;

	logic signed [DW-1:0]   dot;
	logic [MRW-1:0]         max, may, mbx, mby;

	always_comb begin
		dot = DW'(px_s2) + DW'(py_s2);
		max = red_mag(dax_s2);
		may = red_mag(day_s2);
		mbx = red_mag(dbx_s2);
		mby = red_mag(dby_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		// world vertices and twice the ray from the midpoint to the light
		wax_s1 <= WW'(obstacle_x) + WW'(vertex_a_x);
		way_s1 <= WW'(obstacle_y) + WW'(vertex_a_y);
		wbx_s1 <= WW'(obstacle_x) + WW'(vertex_b_x);
		wby_s1 <= WW'(obstacle_y) + WW'(vertex_b_y);
		rx_s1  <= (RXW'(light_x) <<< 1) - (RXW'(obstacle_x) <<< 1)
			- RXW'(vertex_a_x) - RXW'(vertex_b_x);
		ry_s1  <= (RXW'(light_y) <<< 1) - (RXW'(obstacle_y) <<< 1)
			- RXW'(vertex_a_y) - RXW'(vertex_b_y);
		nx_s1  <= normal_x;
		ny_s1  <= normal_y;
		r_s1   <= shade_ch(light_red, edge_red, opacity);
		g_s1   <= shade_ch(light_green, edge_green, opacity);
		b_s1   <= shade_ch(light_blue, edge_blue, opacity);

		px_s2  <= nx_s1 * rx_s1;
		py_s2  <= ny_s1 * ry_s1;
		dax_s2 <= DXW'(light_x) - DXW'(wax_s1);
		day_s2 <= DXW'(light_y) - DXW'(way_s1);
		dbx_s2 <= DXW'(light_x) - DXW'(wbx_s1);
		dby_s2 <= DXW'(light_y) - DXW'(wby_s1);
		wax_s2 <= wax_s1;
		way_s2 <= way_s1;
		wbx_s2 <= wbx_s1;
		wby_s2 <= wby_s1;
		r_s2   <= r_s1;
		g_s2   <= g_s1;
		b_s2   <= b_s1;

		facing_s3 <= (dot < 0);
		sqax_s3 <= SQW'(max) * SQW'(max);
		sqay_s3 <= SQW'(may) * SQW'(may);
		sqbx_s3 <= SQW'(mbx) * SQW'(mbx);
		sqby_s3 <= SQW'(mby) * SQW'(mby);
		prax_s3 <= PRW'(max) * PRW'(window_width);
		pray_s3 <= PRW'(may) * PRW'(window_height);
		prbx_s3 <= PRW'(mbx) * PRW'(window_width);
		prby_s3 <= PRW'(mby) * PRW'(window_height);
		sax_s3  <= dax_s2[DXW-1];
		say_s3  <= day_s2[DXW-1];
		sbx_s3  <= dbx_s2[DXW-1];
		sby_s3  <= dby_s2[DXW-1];
		wax_s3  <= wax_s2;
		way_s3  <= way_s2;
		wbx_s3  <= wbx_s2;
		wby_s3  <= wby_s2;
		r_s3    <= r_s2;
		g_s3    <= g_s2;
		b_s3    <= b_s2;

		fo_s4.side.facing <= facing_s3;
		fo_s4.side.red    <= r_s3;
		fo_s4.side.green  <= g_s3;
		fo_s4.side.blue   <= b_s3;
		fo_s4.side.wax    <= wax_s3;
		fo_s4.side.way    <= way_s3;
		fo_s4.side.wbx    <= wbx_s3;
		fo_s4.side.wby    <= wby_s3;
		fo_s4.side.sax    <= sax_s3;
		fo_s4.side.say    <= say_s3;
		fo_s4.side.sbx    <= sbx_s3;
		fo_s4.side.sby    <= sby_s3;
		fo_s4.side.za     <= (sqax_s3 == '0) && (sqay_s3 == '0);
		fo_s4.side.zb     <= (sqbx_s3 == '0) && (sqby_s3 == '0);
		fo_s4.l2a  <= L2W'(sqax_s3) + L2W'(sqay_s3);
		fo_s4.l2b  <= L2W'(sqbx_s3) + L2W'(sqby_s3);
		fo_s4.na.nx <= NUMW'(prax_s3) << (FRAC_BITS + 8);
		fo_s4.na.ny <= NUMW'(pray_s3) << (FRAC_BITS + 8);
		fo_s4.nb.nx <= NUMW'(prbx_s3) << (FRAC_BITS + 8);
		fo_s4.nb.ny <= NUMW'(prby_s3) << (FRAC_BITS + 8);
	end

	assign out_vld = vld_s4;
	assign fo      = fo_s4;

endmodule

>>> sv/sew_sqrt.sv
// pipelined digit-by-digit square root of the squared length, one root bit per stage
module sew_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  logic [sew_pkg::L2W-1:0]  l2,
	input  sew_pkg::num_pair_t       num_in,
	output logic                     out_vld,
	output logic [sew_pkg::RW-1:0]   root,
	output sew_pkg::num_pair_t       num_out
);
	import sew_pkg::*;

	localparam int RADW = 2 * SQ_STEPS;

	logic              vld_s  [SQ_STEPS+1];
	logic [RADW-1:0]   rad_s  [SQ_STEPS+1];
	logic [RW+1:0]     rem_s  [SQ_STEPS+1];
	logic [RW-1:0]     root_s [SQ_STEPS+1];
	num_pair_t         num_s  [SQ_STEPS+1];

	// length carries 8 fraction bits
	assign vld_s[0]  = in_vld;
	assign rad_s[0]  = RADW'(l2) << 16;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign num_s[0]  = num_in;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic [RW+3:0] cur;
		logic [RW+3:0] trial;
		assign cur   = {rem_s[k], rad_s[k][RADW-1 -: 2]};
		assign trial = {2'b00, root_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			rad_s[k+1] <= rad_s[k] << 2;
			num_s[k+1] <= num_s[k];
			if (cur >= trial) begin
				rem_s[k+1]  <= (RW+2)'(cur - trial);
				root_s[k+1] <= {root_s[k][RW-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= cur[RW+1:0];
				root_s[k+1] <= {root_s[k][RW-2:0], 1'b0};
			end
		end
	end

	assign out_vld = vld_s[SQ_STEPS];
	assign root    = root_s[SQ_STEPS];
	assign num_out = num_s[SQ_STEPS];

endmodule

>>> sv/sew_div.sv
// pipelined restoring divider, one quotient bit per stage
module sew_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  logic [sew_pkg::NUMW-1:0] numer,
	input  logic [sew_pkg::RW-1:0]   den,
	output logic                     out_vld,
	output logic [sew_pkg::QW-1:0]   quo
);
	import sew_pkg::*;

	logic            vld_s [QW+1];
	logic [RW-1:0]   rem_s [QW+1];
	logic [QW-1:0]   low_s [QW+1];
	logic [QW-1:0]   quo_s [QW+1];
	logic [RW-1:0]   den_s [QW+1];

	// upper numerator part is below the divisor since the quotient fits QW bits
	assign vld_s[0] = in_vld;
	assign rem_s[0] = RW'(numer >> QW);
	assign low_s[0] = numer[QW-1:0];
	assign quo_s[0] = '0;
	assign den_s[0] = den;

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW:0] cur;
		logic        ge;
		assign cur = {rem_s[k], low_s[k][QW-1]};
		assign ge  = (cur >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? RW'(cur - {1'b0, den_s[k]}) : RW'(cur);
			low_s[k+1] <= low_s[k] << 1;
			quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
			den_s[k+1] <= den_s[k];
		end
	end

	assign out_vld = vld_s[QW];
	assign quo     = quo_s[QW];

endmodule

>>> sv/shadow_edge_extrusion_2d_top.sv
// top level of the 2d shadow edge extrusion pipeline
// a word passes through the pipeline stages in this order
// (4 front stages, 31 square root stages, 18 divider stages, one output register)
// throughput: one word per clock, set by the fully pipelined root and divider stages
// start is taken whenever high; busy stays low and the receiver cannot stall
// reset clears the pipeline valid bits and loads the register defaults
module shadow_edge_extrusion_2d_top
	import sew_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// command side
	input  logic                    start,
	output logic                    busy,
	input  logic signed [CW-1:0]    obstacle_x,
	input  logic signed [CW-1:0]    obstacle_y,
	input  logic signed [CW-1:0]    vertex_a_x,
	input  logic signed [CW-1:0]    vertex_a_y,
	input  logic signed [CW-1:0]    vertex_b_x,
	input  logic signed [CW-1:0]    vertex_b_y,
	input  logic signed [NRMW-1:0]  normal_x,
	input  logic signed [NRMW-1:0]  normal_y,
	input  logic [CHW-1:0]          edge_red,
	input  logic [CHW-1:0]          edge_green,
	input  logic [CHW-1:0]          edge_blue,
	input  logic signed [OPW-1:0]   opacity,
	// result side
	output logic                    done,
	output logic                    shadowed,
	output logic [CHW-1:0]          shade_red,
	output logic [CHW-1:0]          shade_green,
	output logic [CHW-1:0]          shade_blue,
	output logic signed [CW-1:0]    near_a_x,
	output logic signed [CW-1:0]    near_a_y,
	output logic signed [CW-1:0]    far_a_x,
	output logic signed [CW-1:0]    far_a_y,
	output logic signed [CW-1:0]    far_b_x,
	output logic signed [CW-1:0]    far_b_y,
	output logic signed [CW-1:0]    near_b_x,
	output logic signed [CW-1:0]    near_b_y,
	// register write port
	input  logic                    cfg_we,
	input  logic [IDXW-1:0]         cfg_index,
	input  logic [CW-1:0]           cfg_data
);

	// configuration registers
	logic signed [CW-1:0] light_x_q, light_y_q;
	logic [SCW-1:0]       win_w_q, win_h_q;
	logic [CHW-1:0]       lred_q, lgreen_q, lblue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= '0;
			light_y_q <= '0;
			win_w_q   <= SCW'(640);
			win_h_q   <= SCW'(480);
			lred_q    <= CHW'(127);
			lgreen_q  <= CHW'(127);
			lblue_q   <= CHW'(127);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LIGHT_X:     light_x_q <= cfg_data;
				REG_LIGHT_Y:     light_y_q <= cfg_data;
				REG_WINDOW_W:    win_w_q   <= cfg_data[SCW-1:0];
				REG_WINDOW_H:    win_h_q   <= cfg_data[SCW-1:0];
				REG_LIGHT_RED:   lred_q    <= cfg_data[CHW-1:0];
				REG_LIGHT_GREEN: lgreen_q  <= cfg_data[CHW-1:0];
				REG_LIGHT_BLUE:  lblue_q   <= cfg_data[CHW-1:0];
				default: ;
			endcase
		end
	end

	// every cycle can take a word
	assign busy = 1'b0;

	// front stages: facing test, directions, squared lengths, numerators
	logic   f_vld;
	front_t fo;

	sew_front u_front (
		.clk, .arst_n,
		.in_vld(start),
		.obstacle_x, .obstacle_y, .vertex_a_x, .vertex_a_y, .vertex_b_x, .vertex_b_y,
		.normal_x, .normal_y, .edge_red, .edge_green, .edge_blue, .opacity,
		.light_x(light_x_q), .light_y(light_y_q),
		.window_width(win_w_q), .window_height(win_h_q),
		.light_red(lred_q), .light_green(lgreen_q), .light_blue(lblue_q),
		.out_vld(f_vld), .fo
	);

	// one length per vertex, the numerators ride along
	logic          sa_vld, sb_vld;
	logic [RW-1:0] len_a, len_b;
	num_pair_t     na, nb;

	sew_sqrt u_sqrt_a (
		.clk, .arst_n, .in_vld(f_vld), .l2(fo.l2a), .num_in(fo.na),
		.out_vld(sa_vld), .root(len_a), .num_out(na)
	);

	sew_sqrt u_sqrt_b (
		.clk, .arst_n, .in_vld(f_vld), .l2(fo.l2b), .num_in(fo.nb),
		.out_vld(sb_vld), .root(len_b), .num_out(nb)
	);

	// offset magnitudes per axis
	logic          d_vld, dax_vld, day_vld, dbx_vld, dby_vld;
	logic [QW-1:0] qax, qay, qbx, qby;

	sew_div u_div_ax (
		.clk, .arst_n, .in_vld(sa_vld), .numer(na.nx), .den(len_a),
		.out_vld(dax_vld), .quo(qax)
	);

	sew_div u_div_ay (
		.clk, .arst_n, .in_vld(sa_vld), .numer(na.ny), .den(len_a),
		.out_vld(day_vld), .quo(qay)
	);

	sew_div u_div_bx (
		.clk, .arst_n, .in_vld(sb_vld), .numer(nb.nx), .den(len_b),
		.out_vld(dbx_vld), .quo(qbx)
	);

	sew_div u_div_by (
		.clk, .arst_n, .in_vld(sb_vld), .numer(nb.ny), .den(len_b),
		.out_vld(dby_vld), .quo(qby)
	);

	// all four dividers run in lockstep
	assign d_vld = dax_vld & day_vld & dbx_vld & dby_vld;

	// sideband delay line matching the root and divider depth
	side_t side_d [DLY+1];
	assign side_d[0] = fo.side;

	for (genvar k = 0; k < DLY; k++) begin : g_dly
		always_ff @(posedge clk) begin
			side_d[k+1] <= side_d[k];
		end
	end

	side_t sd;
	assign sd = side_d[DLY];

	// signed offsets, zero for a zero-length direction
	logic signed [FW-1:0] oax, oay, obx, oby;
	logic signed [FW-1:0] fax, fay, fbx, fby;

	always_comb begin
		oax = sd.za ? '0 : (sd.sax ? -FW'(qax) : FW'(qax));
		oay = sd.za ? '0 : (sd.say ? -FW'(qay) : FW'(qay));
		obx = sd.zb ? '0 : (sd.sbx ? -FW'(qbx) : FW'(qbx));
		oby = sd.zb ? '0 : (sd.sby ? -FW'(qby) : FW'(qby));
		// far corner is pushed away from the light
		fax = FW'(sd.wax) - oax;
		fay = FW'(sd.way) - oay;
		fbx = FW'(sd.wbx) - obx;
		fby = FW'(sd.wby) - oby;
	end

	// output register, one strobe per word
	logic                done_q, shadowed_q;
	logic [CHW-1:0]      red_q, green_q, blue_q;
	logic [CW-1:0]       nax_q, nay_q, fax_q, fay_q, fbx_q, fby_q, nbx_q, nby_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= d_vld;
	end

	always_ff @(posedge clk) begin
		if (sd.facing) begin
			shadowed_q <= 1'b1;
			red_q      <= sd.red;
			green_q    <= sd.green;
			blue_q     <= sd.blue;
			nax_q      <= sat_coord(FW'(sd.wax));
			nay_q      <= sat_coord(FW'(sd.way));
			fax_q      <= sat_coord(fax);
			fay_q      <= sat_coord(fay);
			fbx_q      <= sat_coord(fbx);
			fby_q      <= sat_coord(fby);
			nbx_q      <= sat_coord(FW'(sd.wbx));
			nby_q      <= sat_coord(FW'(sd.wby));
		end else begin
			// edge lit from the front: empty word
			shadowed_q <= 1'b0;
			red_q      <= '0;
			green_q    <= '0;
			blue_q     <= '0;
			nax_q      <= '0;
			nay_q      <= '0;
			fax_q      <= '0;
			fay_q      <= '0;
			fbx_q      <= '0;
			fby_q      <= '0;
			nbx_q      <= '0;
			nby_q      <= '0;
		end
	end

	assign done        = done_q;
	assign shadowed    = shadowed_q;
	assign shade_red   = red_q;
	assign shade_green = green_q;
	assign shade_blue  = blue_q;
	assign near_a_x    = nax_q;
	assign near_a_y    = nay_q;
	assign far_a_x     = fax_q;
	assign far_a_y     = fay_q;
	assign far_b_x     = fbx_q;
	assign far_b_y     = fby_q;
	assign near_b_x    = nbx_q;
	assign near_b_y    = nby_q;

endmodule

>>> sv/sew_checker.sv
// port-level checks for the shadow edge extrusion top, bound to it
module sew_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        shadowed,
	input logic [sew_pkg::CHW-1:0]     shade_red,
	input logic signed [sew_pkg::CW-1:0] near_a_x,
	input logic signed [sew_pkg::CW-1:0] far_a_x,
	input logic signed [sew_pkg::CW-1:0] far_b_y
);
	import sew_pkg::*;

	// every accepted word comes out after the fixed latency
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted word produced no result");

	// no result without a word taken at the matching edge
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching word");

	// a lit edge gives an all-zero word
	a_lit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !shadowed |-> shade_red == '0 && near_a_x == '0 && far_a_x == '0
			&& far_b_y == '0)
		else $error("lit edge word not cleared");

endmodule

bind shadow_edge_extrusion_2d_top sew_checker u_sew_checker (.*);

>>> bench/testbench.sv
// self-checking testbench for the 2d shadow edge extrusion block
module testbench;
	import sew_pkg::*;

	typedef struct {
		logic signed [CW-1:0]   obs_x, obs_y, va_x, va_y, vb_x, vb_y;
		logic signed [NRMW-1:0] nrm_x, nrm_y;
		logic [CHW-1:0]         red, green, blue;
		logic signed [OPW-1:0]  opac;
	} edge_word_t;

	typedef struct {
		logic                 shadowed;
		logic [CHW-1:0]       red, green, blue;
		logic signed [CW-1:0] nax, nay, fax, fay, fbx, fby, nbx, nby;
	} quad_word_t;

	// expected shadow quads in order, with a private copy of the light registers
	class quad_scoreboard;
		longint          lx, ly;
		longint unsigned win_w, win_h, lr, lg, lb;
		quad_word_t      pending[$];
		int              errors;

		function void reset_regs();
			lx = 0; ly = 0; win_w = 640; win_h = 480; lr = 127; lg = 127; lb = 127;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CW-1:0] val);
			case (idx)
				REG_LIGHT_X:     lx = longint'($signed(val));
				REG_LIGHT_Y:     ly = longint'($signed(val));
				REG_WINDOW_W:    win_w = val[SCW-1:0];
				REG_WINDOW_H:    win_h = val[SCW-1:0];
				REG_LIGHT_RED:   lr = val[CHW-1:0];
				REG_LIGHT_GREEN: lg = val[CHW-1:0];
				REG_LIGHT_BLUE:  lb = val[CHW-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp_coord(longint v);
			longint hi;
			hi = (longint'(1) <<< (CW - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		function longint unsigned int_root(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else
					r = r >> 1;
				b = b >> 2;
			end
			return r;
		endfunction

		function longint shrink(longint v);
			longint unsigned m;
			m = (v < 0) ? -v : v;
			m = m >> ((CW > 20) ? CW - 20 : 0);
			return (v < 0) ? -longint'(m) : longint'(m);
		endfunction

		function longint push_len(longint c, longint unsigned scale, longint unsigned len);
			longint unsigned m, q;
			m = (c < 0) ? -c : c;
			q = (m * scale * (64'd1 << FRAC_BITS) * 256) / len;
			return (c < 0) ? -longint'(q) : longint'(q);
		endfunction

		// far corner of one world vertex, pushed away from the light
		function void extrude(longint wx, longint wy, output longint fx, output longint fy);
			longint dx, dy, px, py;
			longint unsigned l2, len;
			dx = shrink(lx - wx);
			dy = shrink(ly - wy);
			l2 = dx * dx + dy * dy;
			px = 0; py = 0;
			if (l2 != 0) begin
				len = int_root(l2 << 16);
				px = push_len(dx, win_w, len);
				py = push_len(dy, win_h, len);
			end
			fx = clamp_coord(wx - px);
			fy = clamp_coord(wy - py);
		endfunction

		function logic [CHW-1:0] tint(longint unsigned lc, longint unsigned ec, longint op);
			longint q;
			q = longint'(lc & ec) * op;
			if (q <= 0) return 0;
			q = q >>> 8;
			return (q > 127) ? 127 : q;
		endfunction

		function longint facing_dot(edge_word_t w);
			longint rx2, ry2;
			rx2 = 2 * lx - (2 * longint'(w.obs_x) + w.va_x + w.vb_x);
			ry2 = 2 * ly - (2 * longint'(w.obs_y) + w.va_y + w.vb_y);
			return longint'(w.nrm_x) * rx2 + longint'(w.nrm_y) * ry2;
		endfunction

		function void note_edge(edge_word_t w);
			quad_word_t e;
			longint wax, way, wbx, wby, fax, fay, fbx, fby;
			e = '{default: 0};
			if (facing_dot(w) < 0) begin
				wax = longint'(w.obs_x) + w.va_x; way = longint'(w.obs_y) + w.va_y;
				wbx = longint'(w.obs_x) + w.vb_x; wby = longint'(w.obs_y) + w.vb_y;
				extrude(wax, way, fax, fay);
				extrude(wbx, wby, fbx, fby);
				e.shadowed = 1;
				e.red   = tint(lr, w.red, w.opac);
				e.green = tint(lg, w.green, w.opac);
				e.blue  = tint(lb, w.blue, w.opac);
				e.nax = clamp_coord(wax); e.nay = clamp_coord(way);
				e.fax = fax; e.fay = fay; e.fbx = fbx; e.fby = fby;
				e.nbx = clamp_coord(wbx); e.nby = clamp_coord(wby);
			end
			pending.push_back(e);
		endfunction

		function void cmp(string name, longint exp, longint act);
			if (exp != act) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
				errors++;
			end
		endfunction

		function void check_quad(quad_word_t a);
			quad_word_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none actual shadowed=%0d",
					$time, a.shadowed);
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("shadowed", e.shadowed, a.shadowed);
			cmp("shade_red", e.red, a.red);
			cmp("shade_green", e.green, a.green);
			cmp("shade_blue", e.blue, a.blue);
			cmp("near_a_x", e.nax, a.nax);
			cmp("near_a_y", e.nay, a.nay);
			cmp("far_a_x", e.fax, a.fax);
			cmp("far_a_y", e.fay, a.fay);
			cmp("far_b_x", e.fbx, a.fbx);
			cmp("far_b_y", e.fby, a.fby);
			cmp("near_b_x", e.nbx, a.nbx);
			cmp("near_b_y", e.nby, a.nby);
		endfunction
	endclass

	localparam int WATCHDOG = 5000;

	logic clk = 0, arst_n = 0;
	logic start = 0, busy, done;
	logic signed [CW-1:0] obstacle_x = 0, obstacle_y = 0;
	logic signed [CW-1:0] vertex_a_x = 0, vertex_a_y = 0, vertex_b_x = 0, vertex_b_y = 0;
	logic signed [NRMW-1:0] normal_x = 0, normal_y = 0;
	logic [CHW-1:0] edge_red = 0, edge_green = 0, edge_blue = 0;
	logic signed [OPW-1:0] opacity = 0;
	logic shadowed;
	logic [CHW-1:0] shade_red, shade_green, shade_blue;
	logic signed [CW-1:0] near_a_x, near_a_y, far_a_x, far_a_y;
	logic signed [CW-1:0] far_b_x, far_b_y, near_b_x, near_b_y;
	logic cfg_we = 0;
	logic [IDXW-1:0] cfg_index = 0;
	logic [CW-1:0] cfg_data = 0;

	quad_scoreboard sb = new();
	int idle_cycles = 0;
	logic took_word = 0;

	always #5 clk = ~clk;

	shadow_edge_extrusion_2d_top dut (.*);

	// result side: done marks a single-cycle result, the receiver cannot stall
	always @(posedge clk) begin
		quad_word_t a;
		if (arst_n && done) begin
			a.shadowed = shadowed;
			a.red = shade_red; a.green = shade_green; a.blue = shade_blue;
			a.nax = near_a_x; a.nay = near_a_y; a.fax = far_a_x; a.fay = far_a_y;
			a.fbx = far_b_x; a.fby = far_b_y; a.nbx = near_b_x; a.nby = near_b_y;
			sb.check_quad(a);
		end
	end

	// watchdog: cycles with neither a word taken nor a result seen
	always @(posedge clk) begin
		if (took_word || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("shadow_edge_extrusion_2d_top regression: fail");
			$finish;
		end
	end

	// drive one edge word and hold it until the block takes it
	task automatic send_edge(edge_word_t w);
		obstacle_x <= w.obs_x; obstacle_y <= w.obs_y;
		vertex_a_x <= w.va_x; vertex_a_y <= w.va_y;
		vertex_b_x <= w.vb_x; vertex_b_y <= w.vb_y;
		normal_x <= w.nrm_x; normal_y <= w.nrm_y;
		edge_red <= w.red; edge_green <= w.green; edge_blue <= w.blue;
		opacity <= w.opac;
		start <= 1;
		took_word <= 1;
		do @(posedge clk); while (busy);
		sb.note_edge(w);
	endtask

	// idle gap between bursts; start drops at this same edge
	task automatic pause_sender(int n);
		start <= 0;
		took_word <= 0;
		repeat (n) @(posedge clk);
	endtask

	// caller lowers cfg_we once the batch is done
	task automatic write_reg(reg_idx_t idx, logic [CW-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed(20'($urandom_range(0, 8191))) - 4096;
			2: return $signed(20'($urandom_range(0, 65535))) - 32768;
			default: return $urandom_range(0, 1) ? 20'h7ffff : 20'h80000;
		endcase
	endfunction

	// random edge; most edges that face the light are flipped so they face away from it
	function automatic edge_word_t rand_edge();
		edge_word_t w;
		w.obs_x = rand_coord(); w.obs_y = rand_coord();
		w.va_x = rand_coord(); w.va_y = rand_coord();
		w.vb_x = rand_coord(); w.vb_y = rand_coord();
		w.nrm_x = $signed(16'($urandom_range(0, 32768))) - 16384;
		w.nrm_y = $signed(16'($urandom_range(0, 32768))) - 16384;
		w.red = $urandom; w.green = $urandom; w.blue = $urandom;
		w.opac = $signed(10'($urandom_range(0, 512))) - 256;
		if ($urandom_range(0, 9) < 7 && sb.facing_dot(w) > 0) begin
			w.nrm_x = -w.nrm_x;
			w.nrm_y = -w.nrm_y;
		end
		return w;
	endfunction

	function automatic edge_word_t mk(longint ox, longint oy, longint ax, longint ay,
		longint bx, longint by, longint nx, longint ny, int c, int op);
		edge_word_t w;
		w.obs_x = ox; w.obs_y = oy; w.va_x = ax; w.va_y = ay; w.vb_x = bx; w.vb_y = by;
		w.nrm_x = nx; w.nrm_y = ny; w.red = c; w.green = c; w.blue = c; w.opac = op;
		return w;
	endfunction

	task automatic random_burst(int count);
		int n, burst;
		n = 0;
		while (n < count) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && n < count) begin
				send_edge(rand_edge());
				burst--; n++;
			end
			// sometimes run back to back, sometimes leave a gap
			if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
		end
		pause_sender(0);
	endtask

	task automatic set_light(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] w,
		logic [CW-1:0] h, logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b);
		drain();
		write_reg(REG_LIGHT_X, x);
		write_reg(REG_LIGHT_Y, y);
		write_reg(REG_WINDOW_W, w);
		write_reg(REG_WINDOW_H, h);
		write_reg(REG_LIGHT_RED, r);
		write_reg(REG_LIGHT_GREEN, g);
		write_reg(REG_LIGHT_BLUE, b);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	initial begin
		sb.reset_regs();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed edges under the reset light (at the origin)
		send_edge(mk(0, 0, 0, 0, 0, 0, 0, 0, 127, 256));                 // zero normal
		send_edge(mk(160, 0, 0, 0, 0, 0, 16384, 0, 127, 256));           // faces away
		send_edge(mk(160, 0, 0, 0, 0, 0, -16384, 0, 127, 256));          // faces light
		send_edge(mk(0, 0, 0, 0, 320, 0, 16384, 0, 127, 256));           // vertex at light
		send_edge(mk(0, 0, 0, 0, 0, 0, 16384, 16384, 127, 256));         // dot exactly zero
		send_edge(mk(524287, 524287, 524287, 524287, 524287, 524287,
			16384, 16384, 127, 255));                                     // saturate high
		send_edge(mk(-524288, -524288, -524288, -524288, -524288, -524288,
			-16384, -16384, 127, 256));                                   // saturate low
		send_edge(mk(100, 100, 5, -7, -3, 9, 16384, 16384, 127, -256));  // negative opacity
		send_edge(mk(100, 100, 5, -7, -3, 9, 16384, 16384, 127, -1));
		send_edge(mk(100, 100, 5, -7, -3, 9, 16384, 16384, 127, 0));
		send_edge(mk(100, 100, 5, -7, -3, 9, 16384, 16384, 127, 1));
		send_edge(mk(100, 100, 5, -7, -3, 9, 16384, 16384, 0, 256));
		send_edge(mk(100, 100, 5, -7, -3, 9, 16384, 16384, 85, 200));
		send_edge(mk(-200, 50, 17, 3, -31, -1, -16384, 16384, 42, 128));
		send_edge(mk(1, -1, 0, 0, 0, 0, 16384, -16384, 127, 256));
		pause_sender(3);
		random_burst(130);

		// light in a far corner, a 1 by 1 window, dark light
		set_light(20'h7ffff, 20'h80000, 1, 1, 0, 0, 0);
		random_burst(130);
		// opposite corner, an 8192 by 8192 window, full light
		set_light(20'h80000, 20'h7ffff, 8192, 8192, 127, 127, 127);
		random_burst(130);
		// largest window width, zero window height and a mixed color
		set_light(20'h00140, 20'hfff00, 16383, 0, 85, 42, 127);
		random_burst(130);
		// unused register index must leave everything alone
		drain();
		cfg_we <= 1;
		cfg_index <= 3'd7;
		cfg_data <= 20'hfffff;
		@(posedge clk);
		cfg_we <= 0;
		random_burst(130);
		set_light($urandom, $urandom, $urandom_range(1, 2000), $urandom_range(1, 2000),
			$urandom, $urandom, $urandom);
		random_burst(130);

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("shadow_edge_extrusion_2d_top regression: pass");
		else
			$display("shadow_edge_extrusion_2d_top regression: fail");
		$finish;
	end

endmodule
